### rtl/fwcm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Fixed-wing control mixer package
// Shared types, register indexes, mode codes and pulse constants.
// ----------------------------------------------------------------------------
package fwcm_pkg;

    localparam int unsigned PULSE_W = 11;
    localparam int unsigned CMD_W   = 16;

    typedef logic [PULSE_W-1:0] pulse_t;

    typedef struct packed {
        pulse_t right_aileron;
        pulse_t left_aileron;
        pulse_t elevator;
        pulse_t throttle;
        pulse_t rudder;
    } pulses_t;

    typedef struct packed {
        pulses_t pulses;
        logic    updated;
    } mix_result_t;

    // Configuration register indexes
    localparam logic [1:0] REG_MIXER_MODE = 2'd0;
    localparam logic [1:0] REG_MIX_ENABLE = 2'd1;

    // Mixer mode codes
    localparam logic [2:0] MODE_STANDARD     = 3'd0;
    localparam logic [2:0] MODE_ELEVON       = 3'd1;
    localparam logic [2:0] MODE_VTAIL        = 3'd2;
    localparam logic [2:0] MODE_DUAL_AILERON = 3'd3;
    localparam logic [2:0] MODE_FLAPERON     = 3'd4;

    // Reset pulse widths in microseconds
    localparam pulse_t PULSE_CENTRE   = 11'd1500;
    localparam pulse_t PULSE_THR_IDLE = 11'd1000;

endpackage : fwcm_pkg
`default_nettype wire

### rtl/fwcm_mix.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Fixed-wing control mixer datapath
// Saturates one command set and mixes it into five servo pulse widths.
// ----------------------------------------------------------------------------
module fwcm_mix
(
    input  wire logic signed [15:0] roll_cmd,
    input  wire logic signed [15:0] pitch_cmd,
    input  wire logic signed [15:0] yaw_cmd,
    input  wire logic signed [15:0] throttle_cmd,
    input  wire logic [2:0]         mixer_mode,
    input  wire logic               mix_enable,
    input  wire fwcm_pkg::pulses_t  held,
    output fwcm_pkg::mix_result_t   result
);

    localparam logic signed [15:0] Q14_ONE     = 16'sd16384;
    localparam logic signed [15:0] Q14_NEG_ONE = -16'sd16384;

    // Gains, pre-multiplied by the Q14 mixing coefficients where needed
    localparam logic signed [11:0] G_450  = 12'sd450;
    localparam logic signed [11:0] G_500  = 12'sd500;
    localparam logic signed [11:0] G_1000 = 12'sd1000;
    localparam logic signed [11:0] G_200  = 12'sd200;
    localparam logic signed [24:0] G_YAW_RUD  = 25'sd5161050;  // 11469 * 450
    localparam logic signed [24:0] G_ROLL_RUD = 25'sd1106100;  // 2458 * 450
    localparam logic signed [24:0] G_PITCH_V  = 25'sd8192000;  // 16384 * 500
    localparam logic signed [24:0] G_YAW_V    = 25'sd5734500;  // 11469 * 500
    localparam logic signed [11:0] OFF_MAX    = 12'sd500;
    localparam logic signed [11:0] OFF_MIN    = -12'sd500;

    function automatic logic signed [15:0] sat_sym(input logic signed [15:0] v);
        logic signed [15:0] s;
        s = v;
        if (v > Q14_ONE)
            s = Q14_ONE;
        else if (v < Q14_NEG_ONE)
            s = Q14_NEG_ONE;
        return s;
    endfunction

    function automatic logic signed [15:0] sat_pos(input logic signed [15:0] v);
        logic signed [15:0] s;
        s = v;
        if (v > Q14_ONE)
            s = Q14_ONE;
        else if (v < 16'sd0)
            s = 16'sd0;
        return s;
    endfunction

    function automatic logic signed [15:0] clamp_sum(input logic signed [16:0] v);
        logic signed [15:0] s;
        s = 16'(v);
        if (v > 17'sd16384)
            s = Q14_ONE;
        else if (v < -17'sd16384)
            s = Q14_NEG_ONE;
        return s;
    endfunction

    function automatic logic signed [11:0] clamp_off(input logic signed [11:0] v);
        logic signed [11:0] s;
        s = v;
        if (v > OFF_MAX)
            s = OFF_MAX;
        else if (v < OFF_MIN)
            s = OFF_MIN;
        return s;
    endfunction

    function automatic fwcm_pkg::pulse_t to_pulse(input logic signed [11:0] offs);
        logic signed [11:0] s;
        s = 12'sd1500 + offs;
        return s[10:0];
    endfunction

    function automatic fwcm_pkg::pulse_t to_thr_pulse(input logic signed [11:0] offs);
        logic signed [11:0] s;
        s = 12'sd1000 + offs;
        return s[10:0];
    endfunction

    logic signed [15:0] rs, ps, ys, ts, nrs, nps;
    logic signed [25:0] r450, nr450, np500, t1000, y450, r200, nr200;
    logic signed [25:0] elv_sum500, elv_dif500;
    logic signed [15:0] elv_sum, elv_dif;
    logic signed [39:0] rud_std, vt_sum, vt_dif;

    assign rs  = sat_sym(roll_cmd);
    assign ps  = sat_sym(pitch_cmd);
    assign ys  = sat_sym(yaw_cmd);
    assign ts  = sat_pos(throttle_cmd);
    assign nrs = -rs;
    assign nps = -ps;

    assign r450  = 26'(rs) * 26'(G_450);
    assign nr450 = 26'(nrs) * 26'(G_450);
    assign np500 = 26'(nps) * 26'(G_500);
    assign t1000 = 26'(ts) * 26'(G_1000);
    assign y450  = 26'(ys) * 26'(G_450);
    assign r200  = 26'(rs) * 26'(G_200);
    assign nr200 = 26'(nrs) * 26'(G_200);

    assign elv_sum    = clamp_sum(17'(ps) + 17'(rs));
    assign elv_dif    = clamp_sum(17'(ps) - 17'(rs));
    assign elv_sum500 = 26'(elv_sum) * 26'(G_500);
    assign elv_dif500 = 26'(elv_dif) * 26'(G_500);

    assign rud_std = 40'(ys) * 40'(G_YAW_RUD) + 40'(rs) * 40'(G_ROLL_RUD);
    assign vt_sum  = 40'(ps) * 40'(G_PITCH_V) + 40'(ys) * 40'(G_YAW_V);
    assign vt_dif  = 40'(ps) * 40'(G_PITCH_V) - 40'(ys) * 40'(G_YAW_V);

    fwcm_pkg::pulse_t right_std, left_std, elev_std, thr_p;

    assign right_std = to_pulse(12'(r450 >>> 14));
    assign left_std  = to_pulse(12'(nr450 >>> 14));
    assign elev_std  = to_pulse(12'(np500 >>> 14));
    assign thr_p     = to_thr_pulse(12'(t1000 >>> 14));

    always_comb
    begin
        result.pulses  = held;
        result.updated = 1'b0;
        if (mix_enable)
        begin
            result.updated         = 1'b1;
            result.pulses.throttle = thr_p;
            case (mixer_mode) inside
                fwcm_pkg::MODE_STANDARD, fwcm_pkg::MODE_DUAL_AILERON:
                begin
                    result.pulses.right_aileron = right_std;
                    result.pulses.left_aileron  = left_std;
                    result.pulses.elevator      = elev_std;
                    result.pulses.rudder        = to_pulse(12'(rud_std >>> 28));
                end
                fwcm_pkg::MODE_ELEVON:
                begin
                    result.pulses.elevator      = to_pulse(12'(elv_sum500 >>> 14));
                    result.pulses.right_aileron = to_pulse(12'(elv_dif500 >>> 14));
                    result.pulses.left_aileron  = to_pulse(12'(elv_dif500 >>> 14));
                    result.pulses.rudder        = fwcm_pkg::PULSE_CENTRE;
                end
                fwcm_pkg::MODE_VTAIL:
                begin
                    result.pulses.right_aileron = right_std;
                    result.pulses.left_aileron  = left_std;
                    result.pulses.elevator      = to_pulse(clamp_off(12'(vt_sum >>> 28)));
                    result.pulses.rudder        = to_pulse(clamp_off(12'(vt_dif >>> 28)));
                end
                fwcm_pkg::MODE_FLAPERON:
                begin
                    result.pulses.right_aileron = to_pulse(12'(r200 >>> 14));
                    result.pulses.left_aileron  = to_pulse(12'(nr200 >>> 14));
                    result.pulses.elevator      = elev_std;
                    result.pulses.rudder        = to_pulse(12'(y450 >>> 14));
                end
                default:
                begin
                    // hold on an undefined mode
                    result.pulses  = held;
                    result.updated = 1'b0;
                end
            endcase
        end
    end

endmodule : fwcm_mix
`default_nettype wire

### rtl/fixed_wing_control_mixer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Fixed-wing control mixer
// Mixes roll, pitch, yaw and throttle commands into five servo pulse widths.
// ----------------------------------------------------------------------------
// Each beat passes through an input register and a result register. Throughput:
// one beat per cycle while out_ready is high; the mixer is a single pass of
// constant multiplies and clamps. Reset clears mode and enable and loads the
// held pulses with 1500 us each, throttle 1000 us.
// ----------------------------------------------------------------------------
module fixed_wing_control_mixer
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [2:0]         cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [15:0] roll_cmd,
    input  wire logic signed [15:0] pitch_cmd,
    input  wire logic signed [15:0] yaw_cmd,
    input  wire logic signed [15:0] throttle_cmd,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [10:0]             right_aileron_us,
    output logic [10:0]             left_aileron_us,
    output logic [10:0]             elevator_us,
    output logic [10:0]             throttle_us,
    output logic [10:0]             rudder_us,
    output logic                    outputs_updated
);

    logic [2:0]         mode_reg;
    logic               enable_reg;
    logic               s1_valid_reg, s1_valid_next;
    logic signed [15:0] roll_reg, pitch_reg, yaw_reg, throttle_reg;
    logic               out_valid_reg, out_valid_next;
    fwcm_pkg::pulses_t  held_reg;
    logic               updated_reg;
    fwcm_pkg::mix_result_t mix_res;
    logic               in_fire, s2_ready, s1_advance;

    assign cfg_ready  = 1'b1;
    assign s2_ready   = !out_valid_reg || out_ready;
    assign in_ready   = !s1_valid_reg || s2_ready;
    assign in_fire    = in_valid && in_ready;
    assign s1_advance = s1_valid_reg && s2_ready;

    assign s1_valid_next  = in_fire || (s1_valid_reg && !s2_ready);
    assign out_valid_next = s1_advance || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= fwcm_pkg::MODE_STANDARD;
            enable_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                fwcm_pkg::REG_MIXER_MODE: mode_reg   <= cfg_data;
                fwcm_pkg::REG_MIX_ENABLE: enable_reg <= cfg_data[0];
                default:
                begin
                    // drop writes to unknown registers
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            updated_reg   <= 1'b0;
            held_reg      <= '{right_aileron: fwcm_pkg::PULSE_CENTRE,
                               left_aileron:  fwcm_pkg::PULSE_CENTRE,
                               elevator:      fwcm_pkg::PULSE_CENTRE,
                               throttle:      fwcm_pkg::PULSE_THR_IDLE,
                               rudder:        fwcm_pkg::PULSE_CENTRE};
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_advance)
            begin
                held_reg    <= mix_res.pulses;
                updated_reg <= mix_res.updated;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            roll_reg     <= roll_cmd;
            pitch_reg    <= pitch_cmd;
            yaw_reg      <= yaw_cmd;
            throttle_reg <= throttle_cmd;
        end
    end

    fwcm_mix u_mix
    (
        .roll_cmd     (roll_reg),
        .pitch_cmd    (pitch_reg),
        .yaw_cmd      (yaw_reg),
        .throttle_cmd (throttle_reg),
        .mixer_mode   (mode_reg),
        .mix_enable   (enable_reg),
        .held         (held_reg),
        .result       (mix_res)
    );

    assign out_valid        = out_valid_reg;
    assign right_aileron_us = held_reg.right_aileron;
    assign left_aileron_us  = held_reg.left_aileron;
    assign elevator_us      = held_reg.elevator;
    assign throttle_us      = held_reg.throttle;
    assign rudder_us        = held_reg.rudder;
    assign outputs_updated  = updated_reg;

endmodule : fixed_wing_control_mixer
`default_nettype wire

### sim/tb.sv
// ----------------------------------------------------------------------------
// Fixed-wing control mixer testbench
// Drives roll, pitch, yaw and throttle beats through valid/ready, mirrors the
// mixing rules and the held pulses in a local predictor, and checks every
// result beat field by field. Directed extremes and every mixer mode come
// first. Random phases under varying register settings and random idling
// follow, and a back-to-back burst closes the run.
// ----------------------------------------------------------------------------
module tb;

    localparam longint Q28_ONE     = 268435456;
    localparam longint K_0P7       = 11469;
    localparam longint K_0P15      = 2458;
    localparam longint K_0P5       = 8192;
    localparam longint K_1P5       = 24576;
    localparam int     DRAIN_GAP   = 6;
    localparam int     CYCLE_LIMIT = 400000;
    localparam int     RANDOM_CMDS = 800;
    localparam int     BURST_CMDS  = 100;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [2:0]         cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic signed [15:0] roll_cmd;
    logic signed [15:0] pitch_cmd;
    logic signed [15:0] yaw_cmd;
    logic signed [15:0] throttle_cmd;
    logic               out_valid;
    logic               out_ready;
    logic [10:0]        right_aileron_us;
    logic [10:0]        left_aileron_us;
    logic [10:0]        elevator_us;
    logic [10:0]        throttle_us;
    logic [10:0]        rudder_us;
    logic               outputs_updated;

    logic [2:0]            mode_shadow;
    logic                  enable_shadow;
    fwcm_pkg::pulses_t     servo_hold;
    fwcm_pkg::mix_result_t pending_mix[$];

    bit send_idle;
    bit sink_idle;
    int err_count;
    int cycle_count;
    int cmds_sent;
    int results_seen;
    int reg_writes;
    int mode_hits[8];
    int held_beats;

    fixed_wing_control_mixer u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .roll_cmd         (roll_cmd),
        .pitch_cmd        (pitch_cmd),
        .yaw_cmd          (yaw_cmd),
        .throttle_cmd     (throttle_cmd),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .right_aileron_us (right_aileron_us),
        .left_aileron_us  (left_aileron_us),
        .elevator_us      (elevator_us),
        .throttle_us      (throttle_us),
        .rudder_us        (rudder_us),
        .outputs_updated  (outputs_updated)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        if (v < lo)
        begin
            return lo;
        end
        if (v > hi)
        begin
            return hi;
        end
        return v;
    endfunction

    function automatic fwcm_pkg::pulse_t to_pulse(input longint base, input longint v,
                                                  input longint gain);
        longint acc;
        acc = base * Q28_ONE + v * gain;
        if (acc < 0)
        begin
            acc = 0;
        end
        return fwcm_pkg::pulse_t'(acc >>> 28);
    endfunction

    function automatic fwcm_pkg::mix_result_t mix_command(
        input logic signed [15:0] roll,
        input logic signed [15:0] pitch,
        input logic signed [15:0] yaw,
        input logic signed [15:0] thr);
        longint                rq;
        longint                pq;
        longint                yq;
        longint                tq;
        longint                a;
        longint                b;
        fwcm_pkg::mix_result_t res;
        rq = clip(longint'(roll), -16384, 16384);
        pq = clip(longint'(pitch), -16384, 16384);
        yq = clip(longint'(yaw), -16384, 16384);
        tq = clip(longint'(thr), 0, 16384);
        res.updated = 1'b0;
        if (enable_shadow && mode_shadow <= fwcm_pkg::MODE_FLAPERON)
        begin
            res.updated = 1'b1;
            servo_hold.throttle = to_pulse(1000, tq * 16384, 1000);
            case (mode_shadow)
                fwcm_pkg::MODE_ELEVON:
                begin
                    a = clip((pq + rq) * 16384, -Q28_ONE, Q28_ONE);
                    b = clip((pq - rq) * 16384, -Q28_ONE, Q28_ONE);
                    servo_hold.elevator      = to_pulse(1500, a, 500);
                    servo_hold.right_aileron = to_pulse(1500, b, 500);
                    servo_hold.left_aileron  = to_pulse(1500, b, 500);
                    servo_hold.rudder        = fwcm_pkg::PULSE_CENTRE;
                end
                fwcm_pkg::MODE_VTAIL:
                begin
                    a = clip(pq * 16384 + yq * K_0P7, -Q28_ONE, Q28_ONE);
                    b = clip(pq * 16384 - yq * K_0P7, -Q28_ONE, Q28_ONE);
                    servo_hold.right_aileron = to_pulse(1500, rq * 16384, 450);
                    servo_hold.left_aileron  = to_pulse(1500, -rq * 16384, 450);
                    servo_hold.elevator      = to_pulse(1500, a, 500);
                    servo_hold.rudder        = to_pulse(1500, b, 500);
                end
                fwcm_pkg::MODE_FLAPERON:
                begin
                    a = clip(rq * K_0P5, -Q28_ONE, K_1P5 * 16384);
                    b = clip(-rq * K_0P5, -Q28_ONE, K_1P5 * 16384);
                    servo_hold.right_aileron = to_pulse(1500, a, 400);
                    servo_hold.left_aileron  = to_pulse(1500, b, 400);
                    servo_hold.elevator      = to_pulse(1500, -pq * 16384, 500);
                    servo_hold.rudder        = to_pulse(1500, yq * 16384, 450);
                end
                default:
                begin
                    a = yq * K_0P7 + rq * K_0P15;
                    servo_hold.right_aileron = to_pulse(1500, rq * 16384, 450);
                    servo_hold.left_aileron  = to_pulse(1500, -rq * 16384, 450);
                    servo_hold.elevator      = to_pulse(1500, -pq * 16384, 500);
                    servo_hold.rudder        = to_pulse(1500, a, 450);
                end
            endcase
        end
        res.pulses = servo_hold;
        return res;
    endfunction

    function automatic logic signed [15:0] pick_cmd();
        int sel;
        sel = $urandom_range(0, 11);
        case (sel)
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'(16383 + int'($urandom_range(0, 2)));
            3:       return 16'(-16385 + int'($urandom_range(0, 2)));
            4:       return 16'(int'($urandom_range(0, 64)) - 32);
            5, 6, 7: return 16'(int'($urandom_range(0, 32768)) - 16384);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_mix.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_GAP) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [2:0] data);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        reg_writes++;
        if (idx == fwcm_pkg::REG_MIXER_MODE)
        begin
            mode_shadow = data;
        end
        else if (idx == fwcm_pkg::REG_MIX_ENABLE)
        begin
            enable_shadow = data[0];
        end
    endtask

    task automatic send_cmd(input logic signed [15:0] roll, input logic signed [15:0] pitch,
                            input logic signed [15:0] yaw, input logic signed [15:0] thr);
        fwcm_pkg::mix_result_t want;
        if (send_idle && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        roll_cmd     <= roll;
        pitch_cmd    <= pitch;
        yaw_cmd      <= yaw;
        throttle_cmd <= thr;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        want = mix_command(roll, pitch, yaw, thr);
        if (want.updated)
        begin
            mode_hits[mode_shadow]++;
        end
        else
        begin
            held_beats++;
        end
        pending_mix.push_back(want);
        cmds_sent++;
    endtask

    task automatic send_random();
        send_cmd(pick_cmd(), pick_cmd(), pick_cmd(), pick_cmd());
    endtask

    // disabled after reset, then an undefined mode with enable set
    task automatic test_reset_hold();
        send_cmd(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF);
        send_cmd(16'sd1000, 16'sd2000, -16'sd3000, 16'sd4000);
        write_reg(fwcm_pkg::REG_MIX_ENABLE, 3'd1);
        write_reg(fwcm_pkg::REG_MIXER_MODE, 3'd5);
        send_cmd(16'sd8000, 16'sd8000, 16'sd8000, 16'sd8000);
        write_reg(fwcm_pkg::REG_MIXER_MODE, 3'd7);
        send_cmd(-16'sd8000, 16'sd100, 16'sd0, 16'sd16384);
    endtask

    task automatic test_mode_extremes();
        int m;
        for (m = fwcm_pkg::MODE_STANDARD; m <= fwcm_pkg::MODE_FLAPERON; m++)
        begin
            write_reg(fwcm_pkg::REG_MIXER_MODE, 3'(m));
            send_cmd(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
            send_cmd(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
            send_cmd(16'sd16384, -16'sd16384, 16'sd16384, 16'sd0);
            send_cmd(-16'sd16385, 16'sd16385, -16'sd16384, 16'sd16384);
        end
    endtask

    // unknown indexes ignored; enable takes bit 0 only
    task automatic test_register_decode();
        write_reg(2'd2, 3'd7);
        write_reg(2'd3, 3'd0);
        write_reg(fwcm_pkg::REG_MIX_ENABLE, 3'd6);
        send_cmd(16'sd5000, -16'sd5000, 16'sd5000, 16'sd5000);
        write_reg(fwcm_pkg::REG_MIX_ENABLE, 3'd7);
        write_reg(fwcm_pkg::REG_MIXER_MODE, fwcm_pkg::MODE_DUAL_AILERON);
        send_cmd(16'sd5000, -16'sd5000, 16'sd5000, 16'sd5000);
    endtask

    task automatic test_random_phases();
        int       sent;
        int       chunk;
        int       k;
        bit       paused;
        logic [2:0] mode;
        logic [2:0] en;
        sent   = 0;
        paused = 1'b0;
        while (sent < RANDOM_CMDS)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                mode = 3'($urandom_range(0, 4));
            end
            else
            begin
                mode = 3'($urandom_range(5, 7));
            end
            en = 3'($urandom_range(0, 7));
            if ($urandom_range(0, 4) != 0)
            begin
                en[0] = 1'b1;
            end
            write_reg(fwcm_pkg::REG_MIXER_MODE, mode);
            write_reg(fwcm_pkg::REG_MIX_ENABLE, en);
            if ($urandom_range(0, 3) == 0)
            begin
                write_reg(2'($urandom_range(2, 3)), 3'($urandom_range(0, 7)));
            end
            send_idle = ($urandom_range(0, 3) != 0);
            sink_idle = ($urandom_range(0, 3) != 0);
            chunk = $urandom_range(20, 80);
            for (k = 0; k < chunk; k++)
            begin
                send_random();
                // hold the sender until every result is back
                if (!paused && k == chunk / 2)
                begin
                    wait_drained();
                    paused = 1'b1;
                end
            end
            sent += chunk;
        end
    endtask

    task automatic test_back_to_back();
        int k;
        write_reg(fwcm_pkg::REG_MIXER_MODE, 3'($urandom_range(0, 4)));
        write_reg(fwcm_pkg::REG_MIX_ENABLE, 3'd1);
        send_idle = 1'b0;
        sink_idle = 1'b0;
        for (k = 0; k < BURST_CMDS; k++)
        begin
            send_random();
        end
    endtask

    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (sink_idle && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_mix.size() == 0)
            begin
                report_mismatch("result beat with no command outstanding");
            end
            else
            begin
                fwcm_pkg::mix_result_t want;
                want = pending_mix.pop_front();
                if (right_aileron_us !== want.pulses.right_aileron)
                    report_mismatch($sformatf("right_aileron_us got %0d want %0d",
                                              right_aileron_us, want.pulses.right_aileron));
                if (left_aileron_us !== want.pulses.left_aileron)
                    report_mismatch($sformatf("left_aileron_us got %0d want %0d",
                                              left_aileron_us, want.pulses.left_aileron));
                if (elevator_us !== want.pulses.elevator)
                    report_mismatch($sformatf("elevator_us got %0d want %0d",
                                              elevator_us, want.pulses.elevator));
                if (throttle_us !== want.pulses.throttle)
                    report_mismatch($sformatf("throttle_us got %0d want %0d",
                                              throttle_us, want.pulses.throttle));
                if (rudder_us !== want.pulses.rudder)
                    report_mismatch($sformatf("rudder_us got %0d want %0d",
                                              rudder_us, want.pulses.rudder));
                if (outputs_updated !== want.updated)
                    report_mismatch($sformatf("outputs_updated got %0b want %0b",
                                              outputs_updated, want.updated));
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("fixed_wing_control_mixer verification failed");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        roll_cmd      = '0;
        pitch_cmd     = '0;
        yaw_cmd       = '0;
        throttle_cmd  = '0;
        out_ready     = 1'b0;
        send_idle     = 1'b1;
        sink_idle     = 1'b1;
        mode_shadow   = fwcm_pkg::MODE_STANDARD;
        enable_shadow = 1'b0;
        servo_hold    = '{fwcm_pkg::PULSE_CENTRE, fwcm_pkg::PULSE_CENTRE,
                          fwcm_pkg::PULSE_CENTRE, fwcm_pkg::PULSE_THR_IDLE,
                          fwcm_pkg::PULSE_CENTRE};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_hold();
        test_mode_extremes();
        test_register_decode();
        test_random_phases();
        test_back_to_back();
        wait_drained();

        if (pending_mix.size() != 0)
        begin
            report_mismatch($sformatf("%0d results never arrived", pending_mix.size()));
        end
        $display("Run covered %0d commands, %0d result beats, %0d register writes",
                 cmds_sent, results_seen, reg_writes);
        $display("Mixed: standard %0d elevon %0d vtail %0d dual %0d flaperon %0d; held %0d",
                 mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3], mode_hits[4],
                 held_beats);
        if (err_count == 0)
        begin
            $display("fixed_wing_control_mixer verification clean");
        end
        else
        begin
            $display("fixed_wing_control_mixer verification failed");
        end
        $finish;
    end

endmodule
